FILE: rtl/core/scds_pkg.sv
// Shared types, constants and the divider word packing function for the SPI clock divider search.
package scds_pkg;

  localparam int SRC_W   = 28;
  localparam int FREQ_W  = 32;
  localparam int WORD_W  = 32;
  localparam int N_W     = 6;
  localparam int PRE_W   = 13;
  localparam int DEN_W   = 20;
  localparam int CNT_W   = 5;
  localparam int MIN_RATE_SHIFT = 19;

  localparam logic [SRC_W-1:0]  SRC_RESET     = 28'd80000000;
  localparam logic [N_W-1:0]    N_MAX         = 6'd63;
  localparam logic [PRE_W-1:0]  PRE_MAX       = 13'h1FFF;
  localparam logic [1:0]        K_LAST        = 2'd3;
  localparam logic [WORD_W-1:0] SYSCLK_WORD   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MIN_RATE_WORD = 32'h7FFF_F000;

  typedef enum logic [1:0] {
    DSEL_Q1,
    DSEL_Q2,
    DSEL_RATE
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_Q1_GO,
    ST_Q1_WAIT,
    ST_Q2_GO,
    ST_Q2_WAIT,
    ST_PRE,
    ST_DEN,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_req;
    logic     set_sysclk;
    logic     set_minrate;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_q1;
    logic     set_q2;
    logic     set_pre;
    logic     set_den;
    logic     eval;
    logic     advance;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sysclk;
    logic is_minrate;
    logic div_done;
    logic rate_hit;
    logic last_k;
    logic last_n;
    logic out_busy;
  } status_t;

  function automatic logic [WORD_W-1:0] pack_word(input logic [PRE_W-1:0] pre,
                                                  input logic [N_W-1:0] n);
    logic [N_W:0] n1;
    n1 = {1'b0, n} + 1'b1;
    return {1'b0, pre, n, {N_W{1'b0}}, n1[N_W:1]};
  endfunction

endpackage

FILE: rtl/core/scds_div.sv
// Restoring divider that produces one quotient bit per cycle.
module scds_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [scds_pkg::SRC_W-1:0] dividend,
  input  logic [scds_pkg::SRC_W-1:0] divisor,
  output logic [scds_pkg::SRC_W-1:0] quotient,
  output logic                      done
);
  import scds_pkg::*;

  logic [SRC_W-1:0] rem;
  logic [SRC_W-1:0] quo;
  logic [SRC_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SRC_W:0]   rem_sh;
  logic [SRC_W:0]   diff;
  logic             ge;

  assign rem_sh   = {rem, quo[SRC_W-1]};
  assign diff     = rem_sh - {1'b0, dsr};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CNT_W'(SRC_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[SRC_W-1:0] : rem_sh[SRC_W-1:0];
        quo <= {quo[SRC_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/scds_dpath.sv
// Datapath: request and configuration registers, candidate arithmetic, best match and output.
module scds_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [scds_pkg::FREQ_W-1:0] requested_freq,
  input  logic                        cfg_valid,
  input  logic [scds_pkg::SRC_W-1:0]  source_clock_hz,
  input  scds_pkg::cmd_t              cmd,
  output scds_pkg::status_t           st,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [scds_pkg::WORD_W-1:0] divider_word,
  output logic                        sysclk_select
);
  import scds_pkg::*;

  logic [SRC_W-1:0]  src;
  logic [FREQ_W-1:0] freq;
  logic [N_W-1:0]    n;
  logic [1:0]        k;
  logic [SRC_W-1:0]  q1;
  logic [SRC_W-1:0]  q2;
  logic [PRE_W-1:0]  pre;
  logic [DEN_W-1:0]  den;
  logic [SRC_W-1:0]  best_rate;
  logic [WORD_W-1:0] best_word;

  logic [SRC_W-1:0]  freq_lo;
  logic [N_W:0]      n1;
  logic [SRC_W-1:0]  div_a;
  logic [SRC_W-1:0]  div_b;
  logic [SRC_W-1:0]  rate;
  logic              div_done;
  logic [SRC_W:0]    p_sum;
  logic [PRE_W-1:0]  pre_next;
  logic [PRE_W+N_W+1:0] den_prod;
  logic [WORD_W-1:0] cand_word;

  // Inside the search the request is below the source clock, so its low bits suffice.
  assign freq_lo   = freq[SRC_W-1:0];
  assign n1        = {1'b0, n} + 1'b1;
  assign cand_word = pack_word(pre, n);

  always_comb begin
    case (cmd.div_sel)
      DSEL_Q1: begin
        div_a = src;
        div_b = SRC_W'(n1);
      end
      DSEL_Q2: begin
        div_a = q1;
        div_b = freq_lo;
      end
      DSEL_RATE: begin
        div_a = src;
        div_b = SRC_W'(den);
      end
      default: begin
        div_a = src;
        div_b = SRC_W'(n1);
      end
    endcase
  end

  scds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (rate),
    .done     (div_done)
  );

  // The prescaler is q2 - 2 + k, held between zero and its field maximum.
  assign p_sum = {1'b0, q2} + (SRC_W+1)'(k);

  always_comb begin
    if (p_sum <= (SRC_W+1)'(2)) begin
      pre_next = '0;
    end else if (p_sum > (SRC_W+1)'(PRE_MAX) + (SRC_W+1)'(2)) begin
      pre_next = PRE_MAX;
    end else begin
      pre_next = PRE_W'(p_sum - (SRC_W+1)'(2));
    end
  end

  assign den_prod = ({1'b0, pre} + 1'b1) * n1;

  assign st.is_sysclk  = freq >= FREQ_W'(src);
  assign st.is_minrate = (freq == '0) || (freq < FREQ_W'(src >> MIN_RATE_SHIFT));
  assign st.div_done   = div_done;
  assign st.rate_hit   = rate == freq_lo;
  assign st.last_k     = k == K_LAST;
  assign st.last_n     = n == N_MAX;
  assign st.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src <= SRC_RESET;
    end else if (cfg_valid) begin
      src <= source_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      freq      <= requested_freq;
      n         <= N_W'(1);
      k         <= '0;
      best_rate <= '0;
      best_word <= '0;
    end
    if (cmd.set_sysclk) begin
      best_word <= SYSCLK_WORD;
    end
    if (cmd.set_minrate) begin
      best_word <= MIN_RATE_WORD;
    end
    if (cmd.set_q1) begin
      q1 <= rate;
    end
    if (cmd.set_q2) begin
      q2 <= rate;
    end
    if (cmd.set_pre) begin
      pre <= pre_next;
    end
    if (cmd.set_den) begin
      den <= DEN_W'(den_prod);
    end
    if (cmd.eval) begin
      if (rate == freq_lo) begin
        best_word <= cand_word;
      end else if (rate < freq_lo && rate > best_rate) begin
        best_rate <= rate;
        best_word <= cand_word;
      end
    end
    if (cmd.advance) begin
      if (k == K_LAST) begin
        k <= '0;
        n <= n + 1'b1;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      divider_word  <= best_word;
      sysclk_select <= best_word == SYSCLK_WORD;
    end
  end

endmodule

FILE: rtl/core/scds_ctrl.sv
// Controller state machine that sequences the divider search over N and the four prescaler trials.
module scds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output scds_pkg::cmd_t    cmd,
  input  scds_pkg::status_t st
);
  import scds_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.is_sysclk) begin
          cmd.set_sysclk = 1'b1;
          state_next     = ST_DONE;
        end else if (st.is_minrate) begin
          cmd.set_minrate = 1'b1;
          state_next      = ST_DONE;
        end else begin
          state_next = ST_Q1_GO;
        end
      end
      ST_Q1_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_Q1;
        state_next    = ST_Q1_WAIT;
      end
      ST_Q1_WAIT: begin
        if (st.div_done) begin
          cmd.set_q1 = 1'b1;
          state_next = ST_Q2_GO;
        end
      end
      ST_Q2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_Q2;
        state_next    = ST_Q2_WAIT;
      end
      ST_Q2_WAIT: begin
        if (st.div_done) begin
          cmd.set_q2 = 1'b1;
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.set_pre = 1'b1;
        state_next  = ST_DEN;
      end
      ST_DEN: begin
        cmd.set_den = 1'b1;
        state_next  = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_RATE;
        state_next    = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (st.div_done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        // An exact rate ends the search at once.
        if (st.rate_hit || (st.last_k && st.last_n)) begin
          state_next = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = st.last_k ? ST_Q1_GO : ST_PRE;
        end
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/spi_clock_divider_search_top.sv
// Top level of the SPI clock divider search: controller, datapath and configuration port.
// The undivided and slowest cases skip the search; a full search runs two quotient divisions
// and four rate divisions per value of N on one shared 28-step divider.
// One item is worked on at a time; the next is taken as soon as the result sits in the output
// register. Synchronous active-high reset empties the block and sets the source clock to 80 MHz.
module spi_clock_divider_search_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scds_pkg::FREQ_W-1:0] requested_freq,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scds_pkg::WORD_W-1:0] divider_word,
  output logic                        sysclk_select,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scds_pkg::SRC_W-1:0]  source_clock_hz
);
  import scds_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  scds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  scds_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .requested_freq  (requested_freq),
    .cfg_valid       (cfg_valid),
    .source_clock_hz (source_clock_hz),
    .cmd             (cmd),
    .st              (st),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .divider_word    (divider_word),
    .sysclk_select   (sysclk_select)
  );

endmodule

FILE: rtl/core/scds_check.sv
// Port-level checker for the SPI clock divider search, bound to the top level.
module scds_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [scds_pkg::WORD_W-1:0] divider_word,
  input logic                        sysclk_select
);
  import scds_pkg::*;

  // The select flag and the undivided word always travel together.
  a_sysclk_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sysclk_select == (divider_word == SYSCLK_WORD)))
    else $error("sysclk_select disagrees with divider_word");

  // The unused high-time field of the word is always zero.
  a_h_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (divider_word[11:6] == 6'd0))
    else $error("divider_word bits 11:6 not zero");

  // Once an item is taken the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(divider_word)
                                   && $stable(sysclk_select)))
    else $error("stalled result changed or dropped");

endmodule

bind spi_clock_divider_search_top scds_check u_scds_check (.*);
